// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pixel brightness/contrast block.
// Uses the clk and arst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pbc assertion failed");
`define PBC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("pbc forbidden condition seen");
`else
`define PBC_ASSERT(lbl, prop)
`define PBC_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/pbc_pkg.sv =====
// Package of the pixel brightness/contrast block: payload structs, coefficient
// and pipeline control structs, register indexes and codes. No dependencies.
package pbc_pkg;

	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] chan3;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out0;
		logic [7:0] out1;
		logic [7:0] out2;
		logic [7:0] out3;
	} result_t;

	// per-configuration linear map: num = a*x + off, result = num / den
	typedef struct packed {
		logic signed [17:0] a;
		logic signed [24:0] off;
		logic [15:0]        den;
		logic               thresh;
	} coef_t;

	// load enables of pipeline stages 2..7
	typedef struct packed {
		logic [7:2] adv;
	} ctl_t;

	localparam logic [1:0] CFG_OPERATION = 2'd0;
	localparam logic [1:0] CFG_FORMULA   = 2'd1;
	localparam logic [1:0] CFG_AMOUNT    = 2'd2;
	localparam logic [1:0] CFG_LAYOUT    = 2'd3;

	localparam logic OP_BRIGHT   = 1'b0;
	localparam logic OP_CONTRAST = 1'b1;
	localparam logic MODE_MODERN = 1'b0;
	localparam logic MODE_LEGACY = 1'b1;

	localparam logic [1:0] LAYOUT_GRAY = 2'd0;
	localparam logic [1:0] LAYOUT_RGB  = 2'd1;
	localparam logic [1:0] LAYOUT_RGBA = 2'd2;

	localparam int NUM_W = 26;
	localparam int REM_W = 25;

endpackage

// ===== rtl/pbc_coef.sv =====
// Coefficient builder: turns operation, formula and amount into a*x+off over den.
// Depends on pbc_pkg.
module pbc_coef #(
	parameter int BRIGHT_LIMIT = 150
) (
	input  logic              operation,
	input  logic              formula_mode,
	input  logic signed [8:0] amount,
	output pbc_pkg::coef_t    coef
);

	localparam logic signed [9:0]  LIM   = 10'(BRIGHT_LIMIT);
	localparam logic signed [9:0]  CLIM  = 10'sd100;
	localparam logic signed [25:0] LIM26 = 26'(BRIGHT_LIMIT);

	logic signed [9:0]  amt;
	logic signed [9:0]  b;
	logic signed [9:0]  c;
	logic signed [25:0] b26;
	logic signed [25:0] c26;
	logic signed [25:0] a_w;
	logic signed [25:0] off_w;
	logic signed [25:0] den_w;
	logic               thr_w;

	// saturate the amount for each operation
	always_comb begin
		amt = {amount[8], amount};
		if (amt > LIM) b = LIM;
		else if (amt < -LIM) b = -LIM;
		else b = amt;
		if (amt > CLIM) c = CLIM;
		else if (amt < -CLIM) c = -CLIM;
		else c = amt;
		b26 = 26'(b);
		c26 = 26'(c);
	end

	// pick the linear map of the selected formula
	always_comb begin
		a_w   = 26'sd0;
		off_w = 26'sd0;
		den_w = 26'sd1;
		thr_w = 1'b0;
		if (operation == pbc_pkg::OP_BRIGHT) begin
			if (formula_mode == pbc_pkg::MODE_LEGACY) begin
				a_w   = 26'sd1;
				off_w = b26;
			end else if (b26 >= 0) begin
				a_w   = LIM26 - b26;
				off_w = 26'sd255 * b26;
				den_w = LIM26;
			end else begin
				a_w   = LIM26 + b26;
				den_w = LIM26;
			end
		end else begin
			if (formula_mode == pbc_pkg::MODE_LEGACY) begin
				a_w   = 26'sd259 * c26 + 26'sd25900;
				off_w = -(26'sd65792 * c26);
				den_w = 26'sd25900 - 26'sd255 * c26;
			end else if (c26 == 26'sd100) begin
				thr_w = 1'b1;
			end else if (c26 < 0) begin
				a_w   = 26'sd100 + c26;
				off_w = -(26'sd128 * c26);
				den_w = 26'sd100;
			end else begin
				a_w   = 26'sd100;
				off_w = -(26'sd128 * c26);
				den_w = 26'sd100 - c26;
			end
		end
	end

	assign coef.a      = 18'(a_w);
	assign coef.off    = 25'(off_w);
	assign coef.den    = 16'(den_w);
	assign coef.thresh = thr_w;

endmodule

// ===== rtl/pbc_lane.sv =====
// One channel lane: multiply-add, clamp, and a four-stage rounding divider.
// Depends on pbc_pkg.
module pbc_lane (
	input  logic           clk,
	input  pbc_pkg::ctl_t  ctl,
	input  pbc_pkg::coef_t coef_s1,
	input  logic           adj_s1,
	input  logic [7:0]     x_s1,
	output logic [7:0]     y_s7
);

	localparam int NW = pbc_pkg::NUM_W;
	localparam int RW = pbc_pkg::REM_W;

	// two restoring division steps at quotient bits sh+1 and sh
	function automatic logic [RW+1:0] div_pair(input logic [RW-1:0] r,
			input logic [16:0] d, input logic [2:0] sh);
		logic [RW-1:0] dh;
		logic [RW-1:0] dl;
		logic [RW-1:0] t;
		logic          q1;
		logic          q0;
		dh = RW'({8'd0, d} << (sh + 3'd1));
		dl = RW'({8'd0, d} << sh);
		t  = r;
		q1 = (t >= dh);
		if (q1) t = t - dh;
		q0 = (t >= dl);
		if (q0) t = t - dl;
		return {q1, q0, t};
	endfunction

	logic signed [NW-1:0] a26;
	logic signed [NW-1:0] x26;
	logic signed [NW-1:0] num_w;

	logic signed [NW-1:0] num_s2;
	logic [15:0]          den_s2;
	logic                 thr_s2;
	logic                 adj_s2;
	logic [7:0]           x_s2;

	logic [23:0]          top_w;
	logic                 ovr_w;
	logic [7:0]           oval_w;

	logic                 ovr_s3, ovr_s4, ovr_s5, ovr_s6;
	logic [7:0]           oval_s3, oval_s4, oval_s5, oval_s6;
	logic                 adj_s3, adj_s4, adj_s5, adj_s6;
	logic [7:0]           x_s3, x_s4, x_s5, x_s6;
	logic [RW-1:0]        rem_s3, rem_s4, rem_s5, rem_s6;
	logic [16:0]          d2_s3, d2_s4, d2_s5, d2_s6;
	logic [7:0]           q_s4, q_s5, q_s6;

	logic [RW+1:0]        p4, p5, p6, p7;

	// stage 2: multiply-add
	always_comb begin
		a26   = NW'(coef_s1.a);
		x26   = {18'd0, x_s1};
		num_w = a26 * x26 + NW'(coef_s1.off);
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			num_s2 <= num_w;
			den_s2 <= coef_s1.den;
			thr_s2 <= coef_s1.thresh;
			adj_s2 <= adj_s1;
			x_s2   <= x_s1;
		end
	end

	// stage 3: clamp, threshold case, and divider operands
	always_comb begin
		top_w  = {den_s2, 8'd0} - {8'd0, den_s2};
		ovr_w  = 1'b1;
		oval_w = 8'd0;
		if (thr_s2) begin
			if (x_s2 < 8'd128) oval_w = 8'd0;
			else if (x_s2 > 8'd128) oval_w = 8'd255;
			else oval_w = 8'd128;
		end else if (num_s2 <= 0) begin
			oval_w = 8'd0;
		end else if (num_s2 >= NW'({2'b0, top_w})) begin
			oval_w = 8'd255;
		end else begin
			ovr_w = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			ovr_s3  <= ovr_w;
			oval_s3 <= oval_w;
			adj_s3  <= adj_s2;
			x_s3    <= x_s2;
			rem_s3  <= RW'({num_s2[NW-2:0], 1'b0}) + RW'(den_s2);
			d2_s3   <= {den_s2, 1'b0};
		end
	end

	// stages 4..7: two quotient bits each
	assign p4 = div_pair(rem_s3, d2_s3, 3'd6);
	assign p5 = div_pair(rem_s4, d2_s4, 3'd4);
	assign p6 = div_pair(rem_s5, d2_s5, 3'd2);
	assign p7 = div_pair(rem_s6, d2_s6, 3'd0);

	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			ovr_s4  <= ovr_s3;
			oval_s4 <= oval_s3;
			adj_s4  <= adj_s3;
			x_s4    <= x_s3;
			d2_s4   <= d2_s3;
			rem_s4  <= p4[RW-1:0];
			q_s4    <= {p4[RW+1:RW], 6'd0};
		end
		if (ctl.adv[5]) begin
			ovr_s5  <= ovr_s4;
			oval_s5 <= oval_s4;
			adj_s5  <= adj_s4;
			x_s5    <= x_s4;
			d2_s5   <= d2_s4;
			rem_s5  <= p5[RW-1:0];
			q_s5    <= {q_s4[7:6], p5[RW+1:RW], 4'd0};
		end
		if (ctl.adv[6]) begin
			ovr_s6  <= ovr_s5;
			oval_s6 <= oval_s5;
			adj_s6  <= adj_s5;
			x_s6    <= x_s5;
			d2_s6   <= d2_s5;
			rem_s6  <= p6[RW-1:0];
			q_s6    <= {q_s5[7:4], p6[RW+1:RW], 2'd0};
		end
		// final select: pass-through, clamp/threshold value, or quotient
		if (ctl.adv[7]) begin
			if (!adj_s6) y_s7 <= x_s6;
			else if (ovr_s6) y_s7 <= oval_s6;
			else y_s7 <= {q_s6[7:2], p7[RW+1:RW]};
		end
	end

endmodule

// ===== rtl/pixel_brightness_contrast.sv =====
// Top level of the pixel brightness/contrast block: config registers, stage-1
// capture, valid/stall chain and four lanes. Depends on pbc_pkg, pbc_coef, pbc_lane.
//
//  port group    direction  handshake              payload
//  pixel         in         pixel_valid/stall      pbc_pkg::pixel_t
//  result        out        result_valid/stall     pbc_pkg::result_t
//  cfg           in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One pixel per clock sustained while result_stall is low; seven register stages,
// stage 1 to stage 7, lie between an accepted pixel and its result.
// The divider takes two quotient bits per stage over four stages.
// Each stage holds under stall only if the next one is full, so bubbles close up.
// Reset clears the valid bits and loads the configuration reset values.
// cfg_ready is always high; writes take effect on the next accepted pixel.
`include "assert_macros.svh"
module pixel_brightness_contrast #(
	parameter int BRIGHT_LIMIT = 150
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  pbc_pkg::pixel_t  pixel,
	output logic             result_valid,
	input  logic             result_stall,
	output pbc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [8:0]       cfg_data
);

	logic              operation_q;
	logic              formula_q;
	logic signed [8:0] amount_q;
	logic [1:0]        layout_q;

	pbc_pkg::coef_t    coef_w;
	pbc_pkg::coef_t    coef_s1;
	logic [3:0]        adj_w;
	logic [3:0]        adj_s1;
	logic [7:0]        x_s1 [4];
	logic [7:0]        y_s7 [4];

	logic [7:1]        vld;
	logic [7:1]        rdy;
	pbc_pkg::ctl_t     ctl;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operation_q <= 1'b0;
			formula_q   <= 1'b0;
			amount_q    <= 9'sd0;
			layout_q    <= pbc_pkg::LAYOUT_RGB;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pbc_pkg::CFG_OPERATION: operation_q <= cfg_data[0];
				pbc_pkg::CFG_FORMULA:   formula_q   <= cfg_data[0];
				pbc_pkg::CFG_AMOUNT:    amount_q    <= cfg_data;
				pbc_pkg::CFG_LAYOUT:    layout_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	pbc_coef #(.BRIGHT_LIMIT(BRIGHT_LIMIT)) u_coef (
		.operation    (operation_q),
		.formula_mode (formula_q),
		.amount       (amount_q),
		.coef         (coef_w)
	);

	// channels adjusted under the current layout
	always_comb begin
		case (layout_q)
			pbc_pkg::LAYOUT_GRAY: adj_w = 4'b0001;
			pbc_pkg::LAYOUT_RGB:  adj_w = 4'b0111;
			pbc_pkg::LAYOUT_RGBA: adj_w = 4'b0111;
			default:              adj_w = 4'b0000;
		endcase
	end

	// ready chain: a stage loads when it is empty or the next one loads
	always_comb begin
		rdy[7] = !vld[7] || !result_stall;
		for (int k = 6; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end

	assign ctl.adv     = rdy[7:2];
	assign pixel_stall = !rdy[1];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) vld[1] <= pixel_valid;
			for (int k = 2; k <= 7; k++) begin
				if (rdy[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// stage 1: capture pixel and per-configuration terms
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			coef_s1 <= coef_w;
			adj_s1  <= adj_w;
			x_s1[0] <= pixel.chan0;
			x_s1[1] <= pixel.chan1;
			x_s1[2] <= pixel.chan2;
			x_s1[3] <= pixel.chan3;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		pbc_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.coef_s1 (coef_s1),
			.adj_s1  (adj_s1[g]),
			.x_s1    (x_s1[g]),
			.y_s7    (y_s7[g])
		);
	end

	assign result_valid = vld[7];
	assign result.out0  = y_s7[0];
	assign result.out1  = y_s7[1];
	assign result.out2  = y_s7[2];
	assign result.out3  = y_s7[3];

	`PBC_ASSERT(a_stall_full, pixel_stall |-> vld[1])
	`PBC_NEVER(a_free_flow, !result_stall && pixel_stall)
	`PBC_ASSERT(a_enter_s1, pixel_valid && !pixel_stall |=> vld[1])

endmodule

// ===== bench/tb_pixel_brightness_contrast.sv =====
// Self-checking bench for pixel_brightness_contrast: drives pixels and config writes,
// predicts each untyped pixel in integer rational arithmetic, compares all in order.
// Depends on pbc_pkg and the RTL of the block only.
module tb_pixel_brightness_contrast;

	localparam int BLIM = 150;
	localparam int LATENCY = 7;
	localparam int RAND_ITEMS = 1200;
	localparam longint CYCLE_LIMIT = 400000;

	// short names for the codes used in the stimulus table
	localparam logic OPB = pbc_pkg::OP_BRIGHT;
	localparam logic OPC = pbc_pkg::OP_CONTRAST;
	localparam logic MDN = pbc_pkg::MODE_MODERN;
	localparam logic LGC = pbc_pkg::MODE_LEGACY;
	localparam logic [1:0] L_GRAY = pbc_pkg::LAYOUT_GRAY;
	localparam logic [1:0] L_RGB = pbc_pkg::LAYOUT_RGB;
	localparam logic [1:0] L_RGBA = pbc_pkg::LAYOUT_RGBA;
	localparam logic [1:0] L_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_stall;
	pbc_pkg::pixel_t pixel;
	logic result_valid;
	logic result_stall;
	pbc_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	// shadow copy of the configuration
	logic sh_op;
	logic sh_mode;
	logic signed [8:0] sh_amount;
	logic [1:0] sh_layout;

	pbc_pkg::result_t expected_pixels[$];
	int mismatches;
	int checked;
	longint cycles;
	int cfg_count;
	int stall_left;

	pixel_brightness_contrast #(.BRIGHT_LIMIT(BLIM)) u_top (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// clamp num/den to 0..255 and round half up
	function automatic logic [7:0] clamp_round(longint num, longint den);
		if (num <= 0)
			return 8'd0;
		if (num >= 255 * den)
			return 8'd255;
		return 8'((2 * num + den) / (2 * den));
	endfunction

	function automatic logic [7:0] adjust_byte(logic [7:0] xin);
		longint x, b, c, d, amt;
		x = longint'(xin);
		amt = longint'(sh_amount);
		if (sh_op == pbc_pkg::OP_BRIGHT) begin
			b = (amt > BLIM) ? BLIM : (amt < -BLIM) ? -BLIM : amt;
			if (sh_mode == pbc_pkg::MODE_LEGACY)
				return clamp_round(x + b, 1);
			if (b >= 0)
				return clamp_round(x * BLIM + (255 - x) * b, BLIM);
			return clamp_round(x * (BLIM + b), BLIM);
		end
		c = (amt > 100) ? 100 : (amt < -100) ? -100 : amt;
		if (sh_mode == pbc_pkg::MODE_LEGACY) begin
			d = 5 * (5180 - 51 * c);
			return clamp_round((x - 128) * 259 * (c + 100) + 128 * d, d);
		end
		if (c == 100)
			return (x < 128) ? 8'd0 : (x > 128) ? 8'd255 : 8'd128;
		if (c < 0)
			return clamp_round((x - 128) * (100 + c) + 12800, 100);
		return clamp_round(100 * (x - 128) + 128 * (100 - c), 100 - c);
	endfunction

	function automatic pbc_pkg::result_t adjusted_pixel(pbc_pkg::pixel_t p);
		pbc_pkg::result_t r;
		r = {p.chan0, p.chan1, p.chan2, p.chan3};
		if (sh_layout == pbc_pkg::LAYOUT_GRAY) begin
			r.out0 = adjust_byte(p.chan0);
		end else if (sh_layout == pbc_pkg::LAYOUT_RGB ||
				sh_layout == pbc_pkg::LAYOUT_RGBA) begin
			r.out0 = adjust_byte(p.chan0);
			r.out1 = adjust_byte(p.chan1);
			r.out2 = adjust_byte(p.chan2);
		end
		return r;
	endfunction

	// short gaps mostly, a few long ones, runs with none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic tick(int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pbc_pkg::CFG_OPERATION: sh_op = val[0];
			pbc_pkg::CFG_FORMULA:   sh_mode = val[0];
			pbc_pkg::CFG_AMOUNT:    sh_amount = val;
			default:                sh_layout = val[1:0];
		endcase
		cfg_count++;
	endtask

	// wait until every pixel is back, then let the pipe settle
	task automatic drain();
		while (expected_pixels.size() != 0)
			@(posedge clk);
		tick(LATENCY + 2);
	endtask

	task automatic apply_config(logic op, logic mode, logic signed [8:0] amt, logic [1:0] lay);
		drain();
		write_reg(pbc_pkg::CFG_OPERATION, {8'd0, op});
		write_reg(pbc_pkg::CFG_FORMULA, {8'd0, mode});
		write_reg(pbc_pkg::CFG_AMOUNT, amt);
		write_reg(pbc_pkg::CFG_LAYOUT, {7'd0, lay});
	endtask

	// send one pixel; hold it until accepted; optionally check a typed-in value
	task automatic send_pixel(pbc_pkg::pixel_t p, bit typed, pbc_pkg::result_t want);
		int g;
		g = gap_len();
		if (g != 0) begin
			pixel_valid <= 1'b0;
			tick(g);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		expected_pixels.push_back(typed ? want : adjusted_pixel(p));
		do @(posedge clk); while (pixel_stall);
	endtask

	task automatic end_burst();
		pixel_valid <= 1'b0;
	endtask

	// receiver stall pattern: open cycles between stall runs of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
			stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				pbc_pkg::result_t want;
				want = expected_pixels.pop_front();
				checked++;
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h (op %0d mode %0d amt %0d lay %0d)",
							want, result, sh_op, sh_mode, sh_amount, sh_layout);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	typedef struct {
		logic             op;
		logic             mode;
		logic [8:0]       amt;
		logic [1:0]       lay;
		pbc_pkg::pixel_t  px;
		bit               typed;
		pbc_pkg::result_t want;
	} dir_row_t;

	dir_row_t dir_table[] = '{
		// reset config: modern brightness 0, RGB, identity
		'{OPB, MDN, 9'd0, L_RGB, 32'h00_80_FF_5A, 1, 32'h00_80_FF_5A},
		// brightness saturated to +/-limit gives white or black on adjusted channels
		'{OPB, MDN, 9'd150, L_RGB, 32'h00_10_FF_33, 1, 32'hFF_FF_FF_33},
		'{OPB, MDN, 9'd255, L_RGBA, 32'h00_01_02_FF, 1, 32'hFF_FF_FF_FF},
		'{OPB, MDN, -9'sd150, L_RGB, 32'hFF_80_01_00, 1, 32'h00_00_00_00},
		'{OPB, MDN, -9'sd256, L_GRAY, 32'hFF_80_01_AA, 1, 32'h00_80_01_AA},
		'{OPB, MDN, 9'd75, L_RGB, 32'h01_7F_FE_00, 0, '0},
		'{OPB, MDN, -9'sd1, L_RGB, 32'h01_7F_FF_00, 0, '0},
		// legacy brightness adds the amount with clamping
		'{OPB, LGC, 9'd10, L_RGB, 32'h00_F5_FA_77, 1, 32'h0A_FF_FF_77},
		'{OPB, LGC, -9'sd10, L_RGBA, 32'h05_0A_FF_77, 1, 32'h00_00_F5_77},
		'{OPB, LGC, 9'd255, L_GRAY, 32'h00_00_00_00, 1, 32'h96_00_00_00},
		// modern contrast: full amount thresholds at 128, full negative amount gives 128
		'{OPC, MDN, 9'd100, L_RGB, 32'h7F_80_81_12, 1, 32'h00_80_FF_12},
		'{OPC, MDN, 9'd200, L_RGB, 32'h00_80_FF_12, 1, 32'h00_80_FF_12},
		'{OPC, MDN, -9'sd100, L_RGB, 32'h00_FF_80_34, 1, 32'h80_80_80_34},
		'{OPC, MDN, -9'sd256, L_RGBA, 32'h00_FF_01_34, 1, 32'h80_80_80_34},
		'{OPC, MDN, 9'd99, L_RGB, 32'h7F_80_81_00, 0, '0},
		'{OPC, MDN, 9'd0, L_RGB, 32'h00_80_FF_00, 1, 32'h00_80_FF_00},
		'{OPC, MDN, -9'sd50, L_RGB, 32'h01_81_FF_00, 0, '0},
		// legacy 259 formula at both extremes
		'{OPC, LGC, 9'd100, L_RGB, 32'h00_80_FF_01, 0, '0},
		'{OPC, LGC, -9'sd100, L_RGB, 32'h00_80_FF_01, 1, 32'h80_80_80_01},
		'{OPC, LGC, 9'd37, L_GRAY, 32'h55_80_FF_01, 0, '0},
		// unknown layout passes every byte through
		'{OPC, LGC, 9'd100, L_NONE, 32'h00_55_AA_FF, 1, 32'h00_55_AA_FF},
		'{OPB, MDN, 9'd150, L_NONE, 32'h12_34_56_78, 1, 32'h12_34_56_78}
	};

	initial begin
		logic signed [8:0] amt;
		int r, n;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sh_op = pbc_pkg::OP_BRIGHT;
		sh_mode = pbc_pkg::MODE_MODERN;
		sh_amount = '0;
		sh_layout = pbc_pkg::LAYOUT_RGB;
		mismatches = 0;
		checked = 0;
		cycles = 0;
		cfg_count = 0;
		tick(3);
		arst_n <= 1'b1;
		tick(2);

		// directed table; first row runs on reset configuration
		foreach (dir_table[i]) begin
			if (i != 0)
				apply_config(dir_table[i].op, dir_table[i].mode, dir_table[i].amt,
					dir_table[i].lay);
			send_pixel(dir_table[i].px, dir_table[i].typed, dir_table[i].want);
			end_burst();
		end

		// random bursts, each under a fresh configuration
		n = 0;
		while (n < RAND_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				amt = (r == 0) ? 9'sd255 : -9'sd256;
			else if (r < 4)
				amt = $urandom_range(0, 1) ? 9'sd100 : -9'sd100;
			else
				amt = 9'($urandom_range(0, 300)) - 9'sd150;
			apply_config(1'($urandom), 1'($urandom), amt, 2'($urandom));
			repeat ($urandom_range(10, 60)) begin
				send_pixel(pbc_pkg::pixel_t'($urandom), 0, '0);
				n++;
			end
			end_burst();
		end

		drain();
		$display("Covered %0d checked pixels over %0d register writes, all ops, modes, layouts.",
			checked, cfg_count);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
